[rtl/opad_pkg.sv]
// shared types and constants for the offset point along direction pipeline
package opad_pkg;

	// coordinate and fixed-point format
	localparam int CW = 32;
	localparam int FB = 16;
	// magnitude after range scaling
	localparam int QW = CW - 1;
	// sum of squares and radicand width
	localparam int SW = 2 * CW;
	// threshold register width
	localparam int ML = 16;
	// square root steps, one result bit each
	localparam int SQ_STEPS = SW / 2;
	// quotient bits of a normalised component
	localparam int NQ = FB + 1;

	// input item as carried on the slave tdata, point_x in the lowest bits
	typedef struct packed {
		logic [CW-1:0] offset_amount;
		logic [CW-1:0] origin_z;
		logic [CW-1:0] origin_y;
		logic [CW-1:0] origin_x;
		logic [CW-1:0] point_z;
		logic [CW-1:0] point_y;
		logic [CW-1:0] point_x;
	} in_t;

	// per-item context carried alongside the arithmetic
	typedef struct packed {
		logic [2:0][CW-1:0] p;
		logic [2:0][CW-1:0] mag;
		logic [2:0][QW-1:0] q;
		logic [2:0]         neg;
		logic               dneg;
		logic [CW-1:0]      dmag;
		logic               s;
	} ctx_t;

	typedef struct packed {
		ctx_t          c;
		logic [SW-1:0] sum;
	} sq_in_t;

	typedef struct packed {
		ctx_t          c;
		logic [CW-1:0] root;
	} sq_out_t;

	typedef struct packed {
		ctx_t               c;
		logic [2:0][CW-1:0] dir;
		logic               degen;
	} dv_out_t;

	typedef struct packed {
		logic [2:0][CW-1:0] moved;
		logic               degen;
	} res_t;

endpackage

[rtl/opad_front.sv]
// difference, range scaling, squares and sum of squares (four stages)
module opad_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  opad_pkg::in_t   in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output opad_pkg::sq_in_t out_data
);
	import opad_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4;

	logic [2:0][CW-1:0] p_s1;
	logic [2:0][CW:0]   d_s1;
	logic [CW-1:0]      dist_s1;

	ctx_t               c_s2;
	ctx_t               c_s3;
	logic [2:0][2*QW-1:0] sq_s3;
	sq_in_t             o_s4;

	logic [2:0][CW:0]   mw;
	logic [2:0][CW-1:0] pin;
	logic [2:0][CW-1:0] oin;
	logic               sc;

	// stage advance chain
	assign adv4     = !v_s4 || out_ready;
	assign adv3     = !v_s3 || adv4;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	assign pin = {in_data.point_z, in_data.point_y, in_data.point_x};
	assign oin = {in_data.origin_z, in_data.origin_y, in_data.origin_x};

	// stage 1: exact difference
	always_ff @(posedge clk) begin
		if (adv1) begin
			for (int i = 0; i < 3; i++) begin
				p_s1[i] <= pin[i];
				d_s1[i] <= {pin[i][CW-1], pin[i]} - {oin[i][CW-1], oin[i]};
			end
			dist_s1 <= in_data.offset_amount;
		end
	end

	// magnitudes and the common shift that brings them below 2^(CW-1)
	always_comb begin
		for (int i = 0; i < 3; i++)
			mw[i] = d_s1[i][CW] ? ~d_s1[i] + 1'b1 : d_s1[i];
		sc = mw[0][CW-1] | mw[1][CW-1] | mw[2][CW-1];
	end

	// stage 2: context
	always_ff @(posedge clk) begin
		if (adv2) begin
			for (int i = 0; i < 3; i++) begin
				c_s2.p[i]   <= p_s1[i];
				c_s2.mag[i] <= mw[i][CW-1:0];
				c_s2.q[i]   <= sc ? mw[i][CW-1:1] : mw[i][QW-1:0];
				c_s2.neg[i] <= d_s1[i][CW];
			end
			c_s2.dneg <= dist_s1[CW-1];
			c_s2.dmag <= dist_s1[CW-1] ? ~dist_s1 + 1'b1 : dist_s1;
			c_s2.s    <= sc;
		end
	end

	// stage 3: squares
	always_ff @(posedge clk) begin
		if (adv3) begin
			c_s3 <= c_s2;
			for (int i = 0; i < 3; i++)
				sq_s3[i] <= c_s2.q[i] * c_s2.q[i];
		end
	end

	// stage 4: sum of squares
	always_ff @(posedge clk) begin
		if (adv4) begin
			o_s4.c   <= c_s3;
			o_s4.sum <= SW'(sq_s3[0]) + SW'(sq_s3[1]) + SW'(sq_s3[2]);
		end
	end

	assign out_valid = v_s4;
	assign out_data  = o_s4;

endmodule

[rtl/opad_sqrt.sv]
// digit-by-digit integer square root, one result bit per stage
module opad_sqrt (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  opad_pkg::sq_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output opad_pkg::sq_out_t out_data
);
	import opad_pkg::*;

	localparam int NS = SQ_STEPS;

	logic          v_s   [0:NS];
	logic          adv   [1:NS+1];
	logic [SW-1:0] n_s   [0:NS];
	logic [SW-1:0] res_s [0:NS];
	ctx_t          c_s   [0:NS];

	assign v_s[0]     = in_valid;
	assign n_s[0]     = in_data.sum;
	assign res_s[0]   = '0;
	assign c_s[0]     = in_data.c;
	assign adv[NS+1]  = out_ready;
	assign in_ready   = adv[1];

	for (genvar k = 0; k < NS; k++) begin : g_step
		localparam logic [SW-1:0] STEP_BIT = SW'(1) << (SW - 2 - 2 * k);
		logic [SW-1:0] trial;

		assign adv[k+1] = !v_s[k+1] || adv[k+2];
		assign trial    = res_s[k] + STEP_BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (adv[k+1]) begin
				v_s[k+1] <= v_s[k];
			end
		end

		// subtract the trial value when it fits and set this root bit
		always_ff @(posedge clk) begin
			if (adv[k+1]) begin
				c_s[k+1] <= c_s[k];
				if (n_s[k] >= trial) begin
					n_s[k+1]   <= n_s[k] - trial;
					res_s[k+1] <= (res_s[k] >> 1) + STEP_BIT;
				end else begin
					n_s[k+1]   <= n_s[k];
					res_s[k+1] <= res_s[k] >> 1;
				end
			end
		end
	end

	assign out_valid     = v_s[NS];
	assign out_data.c    = c_s[NS];
	assign out_data.root = res_s[NS][CW-1:0];

endmodule

[rtl/opad_div.sv]
// threshold test and restoring division of each component by the length
module opad_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [opad_pkg::ML-1:0] min_length,
	input  logic              in_valid,
	output logic              in_ready,
	input  opad_pkg::sq_out_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output opad_pkg::dv_out_t out_data
);
	import opad_pkg::*;

	localparam int NS = NQ + 1;

	logic               v_s     [0:NS];
	logic               adv     [1:NS+1];
	ctx_t               c_s     [1:NS];
	logic [CW-1:0]      root_s  [1:NS];
	logic               degen_s [1:NS];
	logic               byp_s   [1:NS];
	logic [2:0][CW-1:0] rem_s   [1:NS];
	logic [2:0][NQ-1:0] quo_s   [1:NS];

	logic [CW:0]        len;
	logic               degen;

	assign v_s[0]    = in_valid;
	assign adv[NS+1] = out_ready;
	assign in_ready  = adv[1];

	for (genvar k = 1; k <= NS; k++) begin : g_hs
		assign adv[k] = !v_s[k] || adv[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (adv[k]) begin
				v_s[k] <= v_s[k-1];
			end
		end
	end

	// full length and the threshold test
	assign len   = in_data.c.s ? {in_data.root, 1'b0} : {1'b0, in_data.root};
	assign degen = len <= (CW+1)'(min_length);

	// stage 1: decision and partial remainder seed
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			c_s[1]     <= in_data.c;
			root_s[1]  <= in_data.root;
			degen_s[1] <= degen;
			byp_s[1]   <= degen || (in_data.root == '0);
			for (int i = 0; i < 3; i++)
				rem_s[1][i] <= CW'(in_data.c.q[i] >> 1);
			quo_s[1] <= '0;
		end
	end

	// one quotient bit per stage
	for (genvar k = 2; k <= NS; k++) begin : g_step
		logic [2:0][CW:0] rin;
		logic [2:0]       fit;

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				rin[i] = {rem_s[k-1][i], (k == 2) ? c_s[k-1].q[i][0] : 1'b0};
				fit[i] = rin[i] >= {1'b0, root_s[k-1]};
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k]) begin
				c_s[k]     <= c_s[k-1];
				root_s[k]  <= root_s[k-1];
				degen_s[k] <= degen_s[k-1];
				byp_s[k]   <= byp_s[k-1];
				for (int i = 0; i < 3; i++) begin
					rem_s[k][i] <= fit[i] ? CW'(rin[i] - {1'b0, root_s[k-1]})
					                      : rin[i][CW-1:0];
					quo_s[k][i] <= {quo_s[k-1][i][NQ-2:0], fit[i]};
				end
			end
		end
	end

	// raw difference magnitude when the length is too short to normalise, else the quotient
	always_comb begin
		out_data.c     = c_s[NS];
		out_data.degen = degen_s[NS];
		for (int i = 0; i < 3; i++)
			out_data.dir[i] = byp_s[NS] ? c_s[NS].mag[i] : CW'(quo_s[NS][i]);
	end

	assign out_valid = v_s[NS];

endmodule

[rtl/opad_back.sv]
// scale by the distance, add to the point and saturate (two stages)
module opad_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  opad_pkg::dv_out_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output opad_pkg::res_t    out_data
);
	import opad_pkg::*;

	localparam int RW = SW - FB + 2;

	logic v_s1, v_s2;
	logic adv1, adv2;

	logic [2:0][SW-1:0] prod_s1;
	logic [2:0][CW-1:0] p_s1;
	logic [2:0]         neg_s1;
	logic               dneg_s1;
	logic               degen_s1;
	res_t               o_s2;

	logic [2:0][RW-1:0] r;
	logic [2:0]         ovf;

	assign adv2     = !v_s2 || out_ready;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	// stage 1: direction magnitude times distance magnitude
	always_ff @(posedge clk) begin
		if (adv1) begin
			for (int i = 0; i < 3; i++)
				prod_s1[i] <= in_data.dir[i] * in_data.c.dmag;
			p_s1     <= in_data.c.p;
			neg_s1   <= in_data.c.neg;
			dneg_s1  <= in_data.c.dneg;
			degen_s1 <= in_data.degen;
		end
	end

	// signed offset added to the point, then clamped
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (neg_s1[i] != dneg_s1)
				r[i] = {{(RW-CW){p_s1[i][CW-1]}}, p_s1[i]} - {2'b00, prod_s1[i][SW-1:FB]};
			else
				r[i] = {{(RW-CW){p_s1[i][CW-1]}}, p_s1[i]} + {2'b00, prod_s1[i][SW-1:FB]};
			ovf[i] = !((&r[i][RW-1:CW-1]) || !(|r[i][RW-1:CW-1]));
		end
	end

	// stage 2: result register
	always_ff @(posedge clk) begin
		if (adv2) begin
			for (int i = 0; i < 3; i++)
				o_s2.moved[i] <= ovf[i] ? {r[i][RW-1], {(CW-1){~r[i][RW-1]}}}
				                        : r[i][CW-1:0];
			o_s2.degen <= degen_s1;
		end
	end

	assign out_valid = v_s2;
	assign out_data  = o_s2;

endmodule

[rtl/offset_point_along_direction.sv]
// top level: moves a point along its direction from a reference point
//
//  channel  | direction | handshake        | payload
//  s_*      | in        | s_tvalid/tready  | tdata: point x,y,z, origin x,y,z, offset_amount
//  m_*      | out       | m_tvalid/tready  | tdata: moved x,y,z; tuser: was_degenerate
//  cfg_*    | in        | cfg_valid/ready  | cfg_data: min_length
//
// one item per cycle while the output is not stalled
// the pipeline includes the 32-stage square root and the 18-stage divider
// reset clears all valid bits and sets min_length to zero
// each stage holds while the one after it is full and stalled, so
// bubbles are squeezed out and input is taken while a result waits
module offset_point_along_direction (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// point_x, point_y, point_z, origin_x, origin_y, origin_z, offset_amount
	input  logic [223:0]  s_tdata,
	output logic          m_tvalid,
	input  logic          m_tready,
	// moved_x, moved_y, moved_z
	output logic [95:0]   m_tdata,
	// was_degenerate
	output logic          m_tuser,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [15:0]   cfg_data
);
	import opad_pkg::*;

	logic [ML-1:0] min_length_q;

	logic    f_valid, f_ready;
	sq_in_t  f_data;
	logic    r_valid, r_ready;
	sq_out_t r_data;
	logic    d_valid, d_ready;
	dv_out_t d_data;
	res_t    res;

	// threshold register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q <= '0;
		end else if (cfg_valid) begin
			min_length_q <= cfg_data;
		end
	end

	opad_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (in_t'(s_tdata)),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_data  (f_data)
	);

	opad_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   (f_data),
		.out_valid (r_valid),
		.out_ready (r_ready),
		.out_data  (r_data)
	);

	opad_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.min_length (min_length_q),
		.in_valid   (r_valid),
		.in_ready   (r_ready),
		.in_data    (r_data),
		.out_valid  (d_valid),
		.out_ready  (d_ready),
		.out_data   (d_data)
	);

	opad_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (d_valid),
		.in_ready  (d_ready),
		.in_data   (d_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (res)
	);

	assign m_tdata = res.moved;
	assign m_tuser = res.degen;

endmodule

[tb/offset_point_along_direction_test.sv]
// testbench for the offset point along direction pipeline: directed table, then random items
`timescale 1ns / 1ps

module offset_point_along_direction_test;
	import opad_pkg::*;

	localparam int PIPE_CYCLES = 56;
	localparam int N_DIRECTED = 14;
	localparam int N_RANDOM = 496;

	typedef struct packed {
		logic [31:0] moved_x;
		logic [31:0] moved_y;
		logic [31:0] moved_z;
		logic        was_degenerate;
	} moved_t;

	typedef struct {
		logic [31:0] px, py, pz, ox, oy, oz, amt;
		logic        known;
		moved_t      res;
	} row_t;

	logic          clk = 0;
	logic          arst_n = 0;
	logic          s_tvalid = 0;
	logic          s_tready;
	logic [223:0]  s_tdata = '0;
	logic          m_tvalid;
	logic          m_tready = 0;
	logic [95:0]   m_tdata;
	logic          m_tuser;
	logic          cfg_valid = 0;
	logic          cfg_ready;
	logic [15:0]   cfg_data = '0;

	logic [15:0] min_length_q = '0;
	moved_t      pending_moves[$];
	int          n_errors = 0;
	row_t        dir_rows[N_DIRECTED];

	offset_point_along_direction uut (.*);

	always #2 clk = ~clk;

	// magnitude of a signed 64-bit value
	function automatic logic [63:0] abs64(input logic signed [63:0] v);
		return v < 0 ? -v : v;
	endfunction

	// expected moved point for one input item
	function automatic moved_t predict_move(input logic [31:0] pt[3], input logic [31:0] org[3],
			input logic [31:0] amt);
		moved_t r;
		logic signed [63:0] dif[3];
		logic signed [63:0] acc;
		logic [63:0] q[3], m, sum, root, rad, bit_v, dmag, dirm, off, len;
		int sh;
		logic degen, dneg;
		m = 0;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			dif[i] = $signed({{32{pt[i][31]}}, pt[i]}) - $signed({{32{org[i][31]}}, org[i]});
			if (abs64(dif[i]) > m) m = abs64(dif[i]);
		end
		dmag = abs64($signed({{32{amt[31]}}, amt}));
		dneg = amt[31];
		sh = 0;
		while (sh < 40 && (m >> sh) >= 64'h8000_0000) sh++;
		for (int i = 0; i < 3; i++) begin
			q[i] = abs64(dif[i]) >> sh;
			sum += q[i] * q[i];
		end
		// digit by digit square root
		rad = sum;
		root = 0;
		bit_v = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (rad >= root + bit_v) begin
				rad -= root + bit_v;
				root = (root >> 1) + bit_v;
			end else begin
				root >>= 1;
			end
			bit_v >>= 2;
		end
		len = root << sh;
		degen = len <= {48'd0, min_length_q};
		for (int i = 0; i < 3; i++) begin
			if (degen || root == 0) dirm = abs64(dif[i]);
			else dirm = (q[i] << FB) / root;
			off = dirm * (dmag >> FB) + ((dirm * (dmag & 64'hFFFF)) >> FB);
			acc = $signed({{32{pt[i][31]}}, pt[i]});
			if ((dif[i] < 0) != dneg) acc -= $signed(off);
			else acc += $signed(off);
			if (acc > 64'sh7FFF_FFFF) acc = 64'sh7FFF_FFFF;
			if (acc < -64'sh8000_0000) acc = -64'sh8000_0000;
			if (i == 0) r.moved_x = acc[31:0];
			if (i == 1) r.moved_y = acc[31:0];
			if (i == 2) r.moved_z = acc[31:0];
		end
		r.was_degenerate = degen;
		return r;
	endfunction

	// one item on the slave side, with an optional gap first; tvalid stays high afterwards
	task automatic send_point(input row_t rw, input int gap);
		logic [31:0] pt[3], org[3];
		moved_t e;
		repeat (gap) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		pt = '{rw.px, rw.py, rw.pz};
		org = '{rw.ox, rw.oy, rw.oz};
		e = predict_move(pt, org, rw.amt);
		if (rw.known && e != rw.res) begin
			$error("table row disagrees with prediction");
			n_errors++;
		end
		s_tvalid <= 1;
		s_tdata <= {rw.amt, rw.oz, rw.oy, rw.ox, rw.pz, rw.py, rw.px};
		pending_moves.push_back(e);
		do @(posedge clk); while (!(s_tvalid && s_tready));
	endtask

	task automatic drain_and_wait();
		s_tvalid <= 0;
		wait (pending_moves.size() == 0);
		repeat (PIPE_CYCLES + 8) @(posedge clk);
	endtask

	task automatic write_min_length(input logic [15:0] v);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		min_length_q = v;
	endtask

	function automatic logic [31:0] rnd_coord();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom_range(0, 255) << 16;
			3: return $signed($urandom_range(0, 2000)) - 1000;
			default: return $urandom;
		endcase
	endfunction

	// receiver stalls on a slow pattern with random phases
	always @(posedge clk) begin
		int ph;
		ph = $urandom_range(0, 15);
		m_tready <= (ph < 11) || ($time / 4000) % 3 == 0;
	end

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		moved_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_moves.size() == 0) begin
				$error("result with nothing expected");
				n_errors++;
			end else begin
				e = pending_moves.pop_front();
				if (m_tdata[31:0] !== e.moved_x) begin
					$error("moved_x exp %h got %h", e.moved_x, m_tdata[31:0]);
					n_errors++;
				end
				if (m_tdata[63:32] !== e.moved_y) begin
					$error("moved_y exp %h got %h", e.moved_y, m_tdata[63:32]);
					n_errors++;
				end
				if (m_tdata[95:64] !== e.moved_z) begin
					$error("moved_z exp %h got %h", e.moved_z, m_tdata[95:64]);
					n_errors++;
				end
				if (m_tuser !== e.was_degenerate) begin
					$error("was_degenerate exp %b got %b", e.was_degenerate, m_tuser);
					n_errors++;
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		row_t rw;
		int burst;
		// directed rows: zero difference, extremes, axis steps, saturation
		dir_rows[0] = '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000,
			32'h0002_0000, 32'h0003_0000, 32'h0005_0000, 1,
			'{32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b1}};
		dir_rows[1] = '{32'h0001_0000, 0, 0, 0, 0, 0, 32'h0002_0000, 1,
			'{32'h0003_0000, 0, 0, 1'b0}};
		dir_rows[2] = '{0, 32'hFFFF_0000, 0, 0, 0, 0, 32'h0001_0000, 1,
			'{0, 32'hFFFE_0000, 0, 1'b0}};
		dir_rows[3] = '{32'h7FFF_FFFF, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 1,
			'{32'h7FFF_FFFF, 0, 0, 1'b0}};
		dir_rows[4] = '{32'h8000_0000, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 1,
			'{32'h8000_0000, 0, 0, 1'b0}};
		dir_rows[5] = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, '{0, 0, 0, 0}};
		dir_rows[6] = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, '{0, 0, 0, 0}};
		dir_rows[7] = '{32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 32'h000A_0000, 0,
			'{0, 0, 0, 0}};
		dir_rows[8] = '{1, 1, 1, 0, 0, 0, 32'hFFFF_FFFF, 0, '{0, 0, 0, 0}};
		dir_rows[9] = '{32'hFFFF_FFFF, 0, 32'h0000_0001, 0, 0, 0, 32'h8000_0000, 0,
			'{0, 0, 0, 0}};
		dir_rows[10] = '{32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
			32'h5555_5555, 32'hAAAA_AAAA, 32'h0001_8000, 0, '{0, 0, 0, 0}};
		dir_rows[11] = '{0, 0, 0, 0, 0, 0, 0, 1, '{0, 0, 0, 1'b1}};
		dir_rows[12] = '{32'h0000_8000, 0, 0, 0, 0, 0, 32'h0001_0000, 0, '{0, 0, 0, 0}};
		dir_rows[13] = '{0, 0, 32'h0010_0000, 0, 0, 0, 32'hFFF0_0000, 0, '{0, 0, 0, 0}};

		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) send_point(dir_rows[i], 0);
		drain_and_wait();

		// threshold settings, extremes included; directed rows again under each
		for (int k = 0; k < 3; k++) begin
			write_min_length(k == 0 ? 16'hFFFF : (k == 1 ? 16'h8000 : 16'h0001));
			for (int i = 0; i < N_DIRECTED; i++) begin
				rw = dir_rows[i];
				rw.known = 0;
				send_point(rw, $urandom_range(0, 2));
			end
			drain_and_wait();
		end

		// random items in bursts, with phase changes of the threshold
		for (int ph = 0; ph < 4; ph++) begin
			write_min_length(ph == 3 ? 16'h0000 : 16'($urandom));
			for (int n = 0; n < N_RANDOM / 4; ) begin
				burst = $urandom_range(1, 20);
				for (int b = 0; b < burst && n < N_RANDOM / 4; b++, n++) begin
					rw.px = rnd_coord(); rw.py = rnd_coord(); rw.pz = rnd_coord();
					if ($urandom_range(0, 9) == 0) begin
						rw.ox = rw.px; rw.oy = rw.py; rw.oz = rw.pz;
					end else begin
						rw.ox = rnd_coord(); rw.oy = rnd_coord(); rw.oz = rnd_coord();
					end
					rw.amt = rnd_coord();
					rw.known = 0;
					send_point(rw, b == 0 ? $urandom_range(0, 12) : 0);
				end
				// hold off until the pipeline is empty now and then
				if ($urandom_range(0, 15) == 0) begin
					s_tvalid <= 0;
					wait (pending_moves.size() == 0);
				end
			end
			drain_and_wait();
		end

		if (n_errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
